@@ sv/mse_pkg.sv @@
// ============================================================================
// mse_pkg
// Shared constants, types and state codes of the merge sort engine.
// ============================================================================
package mse_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned WIDTH  = 32;
  localparam int unsigned IO_W   = 32;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W  = CNT_W + 1;

  typedef logic signed [WIDTH-1:0]  elem_t;
  typedef logic        [ADDR_W-1:0] addr_t;
  typedef logic        [CNT_W-1:0]  cnt_t;
  typedef logic        [SUM_W-1:0]  sum_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_MRD,
    S_MCMP,
    S_ORD,
    S_OLD,
    S_OWAIT
  } state_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    elem_t wdata;
    addr_t raddr_a;
    addr_t raddr_b;
  } ram_req_t;

endpackage

@@ sv/mse_ram.sv @@
// ============================================================================
// mse_ram
// Generic synchronous RAM with one write port and two registered read ports.
// ============================================================================
module mse_ram #(
  parameter int unsigned DEPTH_P = 64,
  parameter int unsigned DATA_W  = 32
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH_P)-1:0] waddr,
  input  logic [DATA_W-1:0]          wdata,
  input  logic [$clog2(DEPTH_P)-1:0] raddr_a,
  input  logic [$clog2(DEPTH_P)-1:0] raddr_b,
  output logic [DATA_W-1:0]          rdata_a,
  output logic [DATA_W-1:0]          rdata_b
);

  logic [DATA_W-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ sv/mse_ctrl.sv @@
// ============================================================================
// mse_ctrl
// Load, bottom-up merge and emit sequencer over two ping-pong RAMs.
// ============================================================================
module mse_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,
  output logic              out_tlast,
  output mse_pkg::ram_req_t req0,
  output mse_pkg::ram_req_t req1,
  input  mse_pkg::elem_t    rd0_a,
  input  mse_pkg::elem_t    rd0_b,
  input  mse_pkg::elem_t    rd1_a,
  input  mse_pkg::elem_t    rd1_b
);
  import mse_pkg::*;

  function automatic cnt_t clamp(input sum_t a, input cnt_t lim);
    clamp = (a < sum_t'(lim)) ? a[CNT_W-1:0] : lim;
  endfunction

  state_t state_r, state_nxt;
  cnt_t   fill_r, fill_nxt;
  cnt_t   n_r, n_nxt;
  cnt_t   width_r, width_nxt;
  cnt_t   i_r, i_nxt;
  cnt_t   j_r, j_nxt;
  cnt_t   mid_r, mid_nxt;
  cnt_t   hi_r, hi_nxt;
  cnt_t   k_r, k_nxt;
  logic   src_r, src_nxt;
  logic   oval_r, oval_nxt;
  logic   olast_r, olast_nxt;
  elem_t  odata_r, odata_nxt;

  elem_t  in_elem;
  elem_t  left_v;
  elem_t  right_v;
  elem_t  pick_v;
  logic   take_right;
  logic   accept;
  logic   set_last;
  cnt_t   k_inc;
  cnt_t   i_inc;
  cnt_t   fill_inc;
  sum_t   w_dbl;

  assign in_elem   = elem_t'(signed'(in_tdata));
  assign left_v    = src_r ? rd1_a : rd0_a;
  assign right_v   = src_r ? rd1_b : rd0_b;
  assign take_right = (i_r >= mid_r) || ((j_r < hi_r) && (right_v < left_v));
  assign pick_v    = take_right ? right_v : left_v;
  assign accept    = in_tvalid && in_tready;
  assign set_last  = in_tlast || (fill_r == cnt_t'(DEPTH - 1));
  assign k_inc     = cnt_t'(k_r + 1'b1);
  assign i_inc     = cnt_t'(i_r + 1'b1);
  assign fill_inc  = cnt_t'(fill_r + 1'b1);
  assign w_dbl     = sum_t'(width_r) << 1;

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = oval_r;
  assign out_tdata  = IO_W'(odata_r);
  assign out_tlast  = olast_r;

  always_comb begin
    req0.we      = 1'b0;
    req0.waddr   = k_r[ADDR_W-1:0];
    req0.wdata   = pick_v;
    req0.raddr_a = i_r[ADDR_W-1:0];
    req0.raddr_b = j_r[ADDR_W-1:0];
    req1         = req0;
    if (state_r == S_LOAD) begin
      req0.we    = accept;
      req0.waddr = fill_r[ADDR_W-1:0];
      req0.wdata = in_elem;
    end else if (state_r == S_MCMP) begin
      req0.we = src_r;
      req1.we = !src_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    n_nxt     = n_r;
    width_nxt = width_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    mid_nxt   = mid_r;
    hi_nxt    = hi_r;
    k_nxt     = k_r;
    src_nxt   = src_r;
    oval_nxt  = oval_r;
    olast_nxt = olast_r;
    odata_nxt = odata_r;
    case (state_r)
      S_LOAD: begin
        if (accept) begin
          fill_nxt = fill_inc;
          if (set_last) begin
            fill_nxt  = '0;
            n_nxt     = fill_inc;
            src_nxt   = 1'b0;
            width_nxt = cnt_t'(1);
            i_nxt     = '0;
            k_nxt     = '0;
            mid_nxt   = clamp(sum_t'(1), fill_inc);
            j_nxt     = clamp(sum_t'(1), fill_inc);
            hi_nxt    = clamp(sum_t'(2), fill_inc);
            state_nxt = (fill_inc > cnt_t'(1)) ? S_MRD : S_ORD;
          end
        end
      end
      S_MRD: begin
        state_nxt = S_MCMP;
      end
      S_MCMP: begin
        k_nxt     = k_inc;
        state_nxt = S_MRD;
        if (take_right) begin
          j_nxt = cnt_t'(j_r + 1'b1);
        end else begin
          i_nxt = i_inc;
        end
        if (k_inc == n_r) begin
          src_nxt = !src_r;
          i_nxt   = '0;
          k_nxt   = '0;
          if (w_dbl < sum_t'(n_r)) begin
            width_nxt = w_dbl[CNT_W-1:0];
            mid_nxt   = clamp(w_dbl, n_r);
            j_nxt     = clamp(w_dbl, n_r);
            hi_nxt    = clamp(w_dbl << 1, n_r);
          end else begin
            state_nxt = S_ORD;
          end
        end else if (k_inc == hi_r) begin
          i_nxt   = hi_r;
          mid_nxt = clamp(sum_t'(hi_r) + sum_t'(width_r), n_r);
          j_nxt   = clamp(sum_t'(hi_r) + sum_t'(width_r), n_r);
          hi_nxt  = clamp(sum_t'(hi_r) + w_dbl, n_r);
        end
      end
      S_ORD: begin
        state_nxt = S_OLD;
      end
      S_OLD: begin
        oval_nxt  = 1'b1;
        odata_nxt = left_v;
        olast_nxt = (i_inc == n_r);
        state_nxt = S_OWAIT;
      end
      S_OWAIT: begin
        if (out_tready) begin
          oval_nxt = 1'b0;
          if (olast_r) begin
            state_nxt = S_LOAD;
          end else begin
            i_nxt     = i_inc;
            state_nxt = S_ORD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      fill_r  <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    width_r <= width_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    mid_r   <= mid_nxt;
    hi_r    <= hi_nxt;
    k_r     <= k_nxt;
    src_r   <= src_nxt;
    olast_r <= olast_nxt;
    odata_r <= odata_nxt;
  end

endmodule

@@ sv/merge_sort_engine_core.sv @@
// ============================================================================
// merge_sort_engine_core
// Stable ascending merge sort of up to 64 signed 32-bit values.
// ============================================================================
// Values arrive on the in_ channel, one per transfer, and are stored in RAM.
// The transfer with in_tlast high, or the one that fills all 64 entries, ends
// the set. The set is then merged bottom-up in runs of width 1, 2, 4 and so
// on, ping-ponging between two RAMs, and leaves on the out_ channel in
// ascending order; out_tlast marks the largest value. Equal values leave in
// arrival order.
// Loading accepts one value per cycle. Each merge pass handles every element
// with a RAM read in S_MRD, then a compare and write in S_MCMP, with
// ceil(log2(n)) passes for a set of n values. Each value leaves through the
// states S_ORD (RAM read), S_OLD (output register load) and S_OWAIT (wait for
// out_tready). The first result of a set is valid after the last merge pass.
// While the block sorts or emits, in_tready is low. A stalled receiver holds
// the output register and the whole emit sequence. Reset empties the store
// and drops any set in progress; the RAMs need no clearing.
// ============================================================================
module merge_sort_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sorted_value
  output logic        out_tlast   // end_of_set
);
  import mse_pkg::*;

  ram_req_t req0;
  ram_req_t req1;
  elem_t    rd0_a;
  elem_t    rd0_b;
  elem_t    rd1_a;
  elem_t    rd1_b;

  mse_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .req0       (req0),
    .req1       (req1),
    .rd0_a      (rd0_a),
    .rd0_b      (rd0_b),
    .rd1_a      (rd1_a),
    .rd1_b      (rd1_b)
  );

  mse_ram #(
    .DEPTH_P (DEPTH),
    .DATA_W  (WIDTH)
  ) u_ram0 (
    .clk     (clk),
    .we      (req0.we),
    .waddr   (req0.waddr),
    .wdata   (req0.wdata),
    .raddr_a (req0.raddr_a),
    .raddr_b (req0.raddr_b),
    .rdata_a (rd0_a),
    .rdata_b (rd0_b)
  );

  mse_ram #(
    .DEPTH_P (DEPTH),
    .DATA_W  (WIDTH)
  ) u_ram1 (
    .clk     (clk),
    .we      (req1.we),
    .waddr   (req1.waddr),
    .wdata   (req1.wdata),
    .raddr_a (req1.raddr_a),
    .raddr_b (req1.raddr_b),
    .rdata_a (rd1_a),
    .rdata_b (rd1_b)
  );

  a_load_emit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while a result is pending");

  a_last_in_stops_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("load continued after the last value of a set");

  a_last_out_reloads: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && !out_tvalid))
    else $error("block did not return to loading after the final result");

  a_no_double_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(req0.we && req1.we))
    else $error("both RAMs written in one cycle");

endmodule
